// ----- rtl/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit allocator: item codes,
// register indexes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

  // Field widths of the stream payload
  localparam int ADDR_W = 16;
  localparam int SIZE_W = 16;

  // Dividend width: a size plus header plus rounding, or a 16-bit offset
  localparam int DIV_W = 17;

  // Bytes of header kept in front of every allocated run
  localparam int HDR_BYTES = 2;

  // Item kinds carried on in_tuser
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_ZERO_SIZE = 1'b1;

  // Register reset values
  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 16'h1C00;
  localparam logic [ADDR_W-1:0] ZERO_SIZE_RST = 16'h7BF8;

  // Result selection for the output register
  typedef enum logic [1:0] {
    RES_ADDR,
    RES_FAIL,
    RES_ZERO,
    RES_FREE
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     div_start;
    logic     scan_start;
    logic     scan_step;
    logic     mark_start;
    logic     free_start;
    logic     walk_step;
    logic     walk_set;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind;
    logic size_zero;
    logic free_ignore;
    logic div_busy;
    logic blk_oob;
    logic scan_hit;
    logic scan_end;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/bffa_div.sv -----
// ----------------------------------------------------------------------------
// bffa_div
// Division by a fixed divisor through reciprocal multiplication; the
// dividend is registered at start and the quotient while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_div #(
  parameter int DW      = 17,
  parameter int DIVISOR = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  output logic               busy,
  output logic [DW-1:0]      quotient
);

  // Scaled reciprocal, exact for every DW-bit dividend
  localparam int     SH   = DW + $clog2(DIVISOR);
  localparam int     MW   = DW + 1;
  localparam int     PW   = DW + MW;
  localparam longint MULT = ((longint'(1) <<< SH) + longint'(DIVISOR) - 1)
                            / longint'(DIVISOR);

  logic [DW-1:0] dvd_r;
  logic          busy_r;
  logic [DW-1:0] quo_r;
  logic [PW-1:0] prod;

  // Multiply by the reciprocal
  always_comb begin
    prod = PW'(dvd_r) * PW'(MULT);
  end

  // Busy for the one cycle the product settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  // Latch the dividend, then take the scaled-down product
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (busy_r) begin
      quo_r <= DW'(prod >> SH);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/bffa_dpath.sv -----
// ----------------------------------------------------------------------------
// bffa_dpath
// Datapath: config registers, item latch, used-flag and run-length memories,
// scan pointers, walk pointers for mark/clear passes, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_dpath #(
  parameter int NUM_BLOCKS  = 3070,
  parameter int BLOCK_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item payload
  input  wire logic                          in_kind,
  input  wire logic [bffa_pkg::SIZE_W-1:0]   in_size,
  input  wire logic [bffa_pkg::ADDR_W-1:0]   in_addr,
  // config writes
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_idx,
  input  wire logic [bffa_pkg::ADDR_W-1:0]   cfg_wdata,
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [bffa_pkg::ADDR_W-1:0]        out_addr,
  output logic                               out_failed,
  // controller link
  input  wire bffa_pkg::cmd_t                cmd,
  output bffa_pkg::sts_t                     sts
);

  localparam int IW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW   = $clog2(NUM_BLOCKS + 1);
  localparam int LW   = CW;
  localparam int QW   = bffa_pkg::DIV_W;
  localparam int CMPW = (CW + 1 > QW) ? CW + 1 : QW;
  localparam int AW   = bffa_pkg::ADDR_W;

  // config registers
  logic [AW-1:0] heap_base_r;
  logic [AW-1:0] zsa_r;

  // item latch
  logic                         kind_r;
  logic [bffa_pkg::SIZE_W-1:0]  size_r;
  logic [AW-1:0]                addr_r;

  // divider
  logic [QW-1:0] div_dividend;
  logic [QW-1:0] quotient;
  logic          div_busy;

  // scan state
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] chk_idx_r;
  logic          chk_vld_r;
  logic [CW-1:0] count_r;
  logic [CW:0]   count_inc;
  logic          scan_hit;
  logic [CW:0]   start_full;
  logic [IW-1:0] start_idx;

  // walk state (reset clear, mark, free clear)
  logic [CW-1:0] wr_idx_r;
  logic [CW-1:0] end_r;
  logic          walk_done;
  logic [IW-1:0] blk_r;
  logic [CW:0]   free_sum;
  logic [CW-1:0] free_end;

  // memories
  logic          used_mem [NUM_BLOCKS];
  logic [LW-1:0] len_mem  [NUM_BLOCKS];
  logic          used_q_r;
  logic [LW-1:0] len_q_r;
  logic [IW-1:0] used_raddr;
  logic [IW-1:0] len_raddr;

  // result
  logic [AW-1:0] res_addr;
  logic [AW-1:0] alloc_addr;
  logic          res_failed;
  logic          out_tvalid_r;
  logic [AW-1:0] out_addr_r;
  logic          out_failed_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= bffa_pkg::HEAP_BASE_RST;
      zsa_r       <= bffa_pkg::ZERO_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        bffa_pkg::CFG_HEAP_BASE: heap_base_r <= cfg_wdata;
        bffa_pkg::CFG_ZERO_SIZE: zsa_r       <= cfg_wdata;
        default:                 heap_base_r <= heap_base_r;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      size_r <= in_size;
      addr_r <= in_addr;
    end
  end

  // Divide size+header rounded up, or the block offset of a freed address
  always_comb begin
    if (kind_r == bffa_pkg::KIND_ALLOC) begin
      div_dividend = QW'(size_r) + QW'(BLOCK_BYTES + bffa_pkg::HDR_BYTES - 1);
    end else begin
      div_dividend = QW'(AW'(addr_r - AW'(bffa_pkg::HDR_BYTES) - heap_base_r));
    end
  end

  bffa_div #(
    .DW      (QW),
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Scan: run counter, hit test and run start
  always_comb begin
    count_inc  = {1'b0, count_r} + 1'b1;
    scan_hit   = chk_vld_r && !used_q_r && (CMPW'(count_inc) >= CMPW'(quotient));
    start_full = {1'b0, chk_idx_r} + 1'b1 - (CW + 1)'(quotient);
    start_idx  = start_full[IW-1:0];
  end

  // Advance scan pointers; read data is registered and pairs with chk_idx_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_idx_r <= '0;
      chk_vld_r <= 1'b0;
      count_r   <= '0;
    end else if (cmd.scan_start) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      count_r   <= '0;
    end else if (cmd.scan_step) begin
      if (rd_idx_r < CW'(NUM_BLOCKS)) begin
        rd_idx_r  <= rd_idx_r + 1'b1;
        chk_idx_r <= rd_idx_r;
        chk_vld_r <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
      if (chk_vld_r) begin
        count_r <= used_q_r ? '0 : count_inc[CW-1:0];
      end
    end
  end

  // Free run end, clipped to the end of the map
  always_comb begin
    free_sum = {1'b0, quotient[CW-1:0]} + (CW + 1)'(len_q_r);
    free_end = (free_sum > (CW + 1)'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : free_sum[CW-1:0];
  end

  // Walk pointers; reset starts a clearing pass over the whole map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      end_r    <= CW'(NUM_BLOCKS);
    end else if (cmd.mark_start) begin
      wr_idx_r <= CW'(start_idx);
      end_r    <= chk_idx_r + 1'b1;
    end else if (cmd.free_start) begin
      wr_idx_r <= quotient[CW-1:0];
      end_r    <= free_end;
    end else if (cmd.walk_step) begin
      wr_idx_r <= wr_idx_r + 1'b1;
    end
  end

  assign walk_done = (wr_idx_r >= end_r);

  // Hold the start block of an allocated run
  always_ff @(posedge clk) begin
    if (cmd.mark_start) begin
      blk_r <= start_idx;
    end
  end

  // Read addresses, kept inside the map
  always_comb begin
    used_raddr = (rd_idx_r < CW'(NUM_BLOCKS)) ? rd_idx_r[IW-1:0] : '0;
    len_raddr  = (quotient < QW'(NUM_BLOCKS)) ? quotient[IW-1:0] : '0;
  end

  // Used-flag memory
  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      used_mem[wr_idx_r[IW-1:0]] <= cmd.walk_set;
    end
    used_q_r <= used_mem[used_raddr];
  end

  // Run-length memory
  always_ff @(posedge clk) begin
    if (cmd.mark_start) begin
      len_mem[start_idx] <= quotient[LW-1:0];
    end
    len_q_r <= len_mem[len_raddr];
  end

  // Result value for the selected outcome
  always_comb begin
    alloc_addr = heap_base_r + AW'(blk_r * AW'(BLOCK_BYTES)) + AW'(bffa_pkg::HDR_BYTES);
    res_addr   = '0;
    res_failed = 1'b0;
    case (cmd.res_sel)
      bffa_pkg::RES_ADDR: res_addr = alloc_addr;
      bffa_pkg::RES_FAIL: res_failed = 1'b1;
      bffa_pkg::RES_ZERO: res_addr = zsa_r;
      bffa_pkg::RES_FREE: res_addr = '0;
      default:            res_addr = '0;
    endcase
  end

  // Output register: load a result, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_addr_r   <= res_addr;
      out_failed_r <= res_failed;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_addr   = out_addr_r;
  assign out_failed = out_failed_r;

  // Status to the controller
  always_comb begin
    sts.kind        = kind_r;
    sts.size_zero   = (size_r == '0);
    sts.free_ignore = (addr_r == '0) || (addr_r == zsa_r);
    sts.div_busy    = div_busy;
    sts.blk_oob     = (quotient >= QW'(NUM_BLOCKS));
    sts.scan_hit    = scan_hit;
    sts.scan_end    = !chk_vld_r && (rd_idx_r == CW'(NUM_BLOCKS));
    sts.walk_done   = walk_done;
    sts.out_free    = !out_tvalid_r || out_tready;
  end

  // Walk never runs past its end
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !walk_done)
    else $error("walk step past run end");

  // Marking starts only on a found run
  a_mark_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_start |-> scan_hit)
    else $error("mark started without a hit");

  // Marked span equals the requested block count
  a_mark_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_start |=> (CMPW'(end_r - wr_idx_r) == CMPW'($past(quotient))))
    else $error("mark span differs from request");

  // Divider is not restarted while busy
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A pending result is never overwritten
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ----- rtl/bffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bffa_ctrl
// Controller: sequences reset clearing, size/address division, map scan,
// run marking, run clearing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output bffa_pkg::cmd_t       cmd,
  input  wire bffa_pkg::sts_t  sts
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_NEED_DIV,
    S_SCAN,
    S_MARK,
    S_BLK_DIV,
    S_LEN_WAIT,
    S_CLEAR,
    S_RESULT
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  bffa_pkg::res_sel_t res_sel_r;
  bffa_pkg::res_sel_t res_sel_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    res_sel_nxt = res_sel_r;
    cmd         = '0;
    cmd.res_sel = res_sel_r;
    case (state_r)
      S_INIT: begin
        if (sts.walk_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == bffa_pkg::KIND_ALLOC) begin
          if (sts.size_zero) begin
            res_sel_nxt = bffa_pkg::RES_ZERO;
            state_nxt   = S_RESULT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_NEED_DIV;
          end
        end else if (sts.free_ignore) begin
          res_sel_nxt = bffa_pkg::RES_FREE;
          state_nxt   = S_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_BLK_DIV;
        end
      end
      S_NEED_DIV: begin
        if (!sts.div_busy) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.mark_start = 1'b1;
          state_nxt      = S_MARK;
        end else if (sts.scan_end) begin
          res_sel_nxt = bffa_pkg::RES_FAIL;
          state_nxt   = S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MARK: begin
        if (sts.walk_done) begin
          res_sel_nxt = bffa_pkg::RES_ADDR;
          state_nxt   = S_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.walk_set  = 1'b1;
        end
      end
      S_BLK_DIV: begin
        if (!sts.div_busy) begin
          if (sts.blk_oob) begin
            res_sel_nxt = bffa_pkg::RES_FREE;
            state_nxt   = S_RESULT;
          end else begin
            state_nxt = S_LEN_WAIT;
          end
        end
      end
      S_LEN_WAIT: begin
        cmd.free_start = 1'b1;
        state_nxt      = S_CLEAR;
      end
      S_CLEAR: begin
        if (sts.walk_done) begin
          res_sel_nxt = bffa_pkg::RES_FREE;
          state_nxt   = S_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result selection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      res_sel_r <= bffa_pkg::RES_FREE;
    end else begin
      state_r   <= state_nxt;
      res_sel_r <= res_sel_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // No item is taken before the clearing pass ends
  a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_tready)
    else $error("item accepted during map clear");

  // A result load always leaves for idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");

  // Scan and mark commands never overlap
  a_scan_mark: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_step && cmd.mark_start))
    else $error("scan step with mark start");

endmodule

`default_nettype wire

// ----- rtl/bitmap_first_fit_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// Heap allocator over a used-flag map of fixed-size blocks, first fit.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tuser=kind, tdata=size_bytes,address
//  out_    | out | out_tvalid/out_tready | tuser=failed, tdata=result_address
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Allocate: decode, block count by division, map scan (one map entry per
//   cycle through the used-flag read port), run marking and the result;
//   a failed scan skips marking, and a zero size goes straight to the result.
// Free: decode, block index by division, length read, run clearing, result;
//   an ignored address skips to the result, as does an index off the map.
// After reset the map is cleared one entry per cycle, with in_tready low;
//   config writes are taken at any time.
// A finished result waits in the output register; the next beat is taken
//   meanwhile and that item stalls only at its own hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_allocator_core #(
  parameter int NUM_BLOCKS  = 3070,
  parameter int BLOCK_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] size_bytes, [31:16] address
  input  wire logic        in_tuser,   // [0] kind
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] result_address
  output logic             out_tuser,  // [0] failed
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bffa_dpath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tuser),
    .in_size    (in_tdata[15:0]),
    .in_addr    (in_tdata[31:16]),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_addr   (out_tdata),
    .out_failed (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire
